// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the cache directory.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: rtl/plcd_pkg.sv
// Package of the paged LRU cache directory: field widths, request and result
// types, controller states and the command and status structs. No dependencies.
package plcd_pkg;

	localparam int ADDR_BITS      = 19;
	localparam int SLOT_BITS      = 6;
	localparam int OFFSET_BITS    = 9;
	localparam int PAGE_BITS      = 10;
	localparam int LIMIT_BITS     = 17;
	localparam int APB_DATA_BITS  = 32;
	localparam int APB_ADDR_BITS  = 3;

	localparam logic REG_RESIDENT_LIMIT = 1'b0;

	typedef struct packed {
		logic                 operation;
		logic [ADDR_BITS-1:0] address;
	} req_t;

	typedef struct packed {
		logic                   in_resident;
		logic [SLOT_BITS-1:0]   slot;
		logic [OFFSET_BITS-1:0] offset;
		logic                   buffer_hit;
		logic                   fill_needed;
		logic [PAGE_BITS-1:0]   fill_page;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_SHIFT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_req;
		logic scan_start;
		logic scan_run;
		logic finish;
		logic shift_run;
		logic out_load;
		logic out_from_check;
	} cmd_t;

	typedef struct packed {
		logic resident;
		logic buf_hit;
		logic found;
		logic exhausted;
		logic shift_done;
		logic out_free;
	} sts_t;

endpackage

// File: rtl/plcd_stream_if.sv
// Valid/ready stream interface carrying one request or result per transfer.
// The payload type is supplied by the instantiating level, usually from plcd_pkg.
interface plcd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/plcd_ctrl.sv
// Controller of the cache directory: sequences check, recency search,
// move-to-front and result load. Depends on plcd_pkg.
module plcd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  plcd_pkg::sts_t sts,
	output plcd_pkg::cmd_t cmd
);

	plcd_pkg::state_t state_q;
	plcd_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plcd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			plcd_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = plcd_pkg::ST_CHECK;
				end
			end
			plcd_pkg::ST_CHECK: begin
				if (sts.resident || sts.buf_hit) begin
					if (sts.out_free) begin
						state_d = plcd_pkg::ST_IDLE;
					end
				end else begin
					state_d = plcd_pkg::ST_SCAN;
				end
			end
			plcd_pkg::ST_SCAN: begin
				if (sts.found || sts.exhausted) begin
					state_d = plcd_pkg::ST_SHIFT;
				end
			end
			plcd_pkg::ST_SHIFT: begin
				if (sts.shift_done) begin
					state_d = plcd_pkg::ST_DONE;
				end
			end
			plcd_pkg::ST_DONE: begin
				if (sts.out_free) begin
					state_d = plcd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = plcd_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			plcd_pkg::ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.load_req = in_valid;
			end
			plcd_pkg::ST_CHECK: begin
				if (sts.resident || sts.buf_hit) begin
					cmd.out_load       = sts.out_free;
					cmd.out_from_check = 1'b1;
				end else begin
					cmd.scan_start = 1'b1;
				end
			end
			plcd_pkg::ST_SCAN: begin
				if (sts.found || sts.exhausted) begin
					cmd.finish = 1'b1;
				end else begin
					cmd.scan_run = 1'b1;
				end
			end
			plcd_pkg::ST_SHIFT: begin
				cmd.shift_run = 1'b1;
			end
			plcd_pkg::ST_DONE: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// File: rtl/plcd_dp.sv
// Datapath of the cache directory: tag and recency memories, stream buffers,
// search pipeline and result register. Depends on plcd_pkg.
module plcd_dp #(
	parameter int SLOTS        = 64,
	parameter int PAGE_BYTES   = 512,
	parameter int ADDRESS_BITS = 19
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  plcd_pkg::cmd_t                      cmd,
	output plcd_pkg::sts_t                      sts,
	input  plcd_pkg::req_t                      req_data,
	input  logic [plcd_pkg::LIMIT_BITS-1:0]     resident_limit,
	output logic                                out_valid,
	input  logic                                out_ready,
	output plcd_pkg::rsp_t                      out_data
);

	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int OFF_W   = $clog2(PAGE_BYTES);
	localparam int PAGE_W  = ADDRESS_BITS - OFF_W;
	localparam int LIM_W   = plcd_pkg::LIMIT_BITS;
	localparam int CMP_W   = (ADDRESS_BITS > LIM_W) ? ADDRESS_BITS : LIM_W;
	localparam int O_SLOT  = plcd_pkg::SLOT_BITS;
	localparam int O_OFF   = plcd_pkg::OFFSET_BITS;
	localparam int O_PAGE  = plcd_pkg::PAGE_BITS;
	localparam logic [SLOT_W-1:0] LAST_POS = SLOT_W'(SLOTS - 1);

	logic                    op_q;
	logic [ADDRESS_BITS-1:0] addr_q;
	logic [PAGE_W-1:0]       page;
	logic [OFF_W-1:0]        offs;
	logic [SLOT_W-1:0]       code_last_q;
	logic [SLOT_W-1:0]       data_last_q;
	logic [SLOT_W-1:0]       last_slot;
	logic                    resident;

	logic [PAGE_W-1:0]       tag_mem [SLOTS];
	logic [SLOTS-1:0]        tag_valid_q;
	logic [PAGE_W-1:0]       tag_rd_q;
	logic [SLOT_W-1:0]       tag_ra;
	logic                    tag_re;
	logic                    tag_we;

	logic [SLOT_W-1:0]       order_mem [SLOTS];
	logic [SLOTS-1:0]        order_set_q;
	logic [SLOT_W-1:0]       order_rd_q;
	logic [SLOT_W-1:0]       order_ra;
	logic [SLOT_W-1:0]       order_wd;
	logic                    order_re;

	logic [SLOT_W-1:0]       pos_q;
	logic                    iss_q;
	logic                    v_s1;
	logic                    order_set_s1;
	logic [SLOT_W-1:0]       pos_s1;
	logic [SLOT_W-1:0]       slot_s1;
	logic                    v_s2;
	logic [SLOT_W-1:0]       pos_s2;
	logic [SLOT_W-1:0]       slot_s2;
	logic                    hit_s2;

	logic [SLOT_W-1:0]       res_slot_q;
	logic [SLOT_W-1:0]       stop_pos_q;
	logic                    fill_q;
	logic [SLOT_W-1:0]       sh_q;
	logic                    out_valid_q;

	assign page      = addr_q[ADDRESS_BITS-1:OFF_W];
	assign offs      = addr_q[OFF_W-1:0];
	assign last_slot = op_q ? data_last_q : code_last_q;
	assign resident  = op_q && (CMP_W'(addr_q) < CMP_W'(resident_limit));

	// An order entry never written since reset holds its own position.
	assign slot_s1 = order_set_s1 ? order_rd_q : pos_s1;
	assign hit_s2  = v_s2 && tag_valid_q[slot_s2] && (tag_rd_q == page);

	always_comb begin
		sts.resident   = resident;
		sts.buf_hit    = tag_valid_q[last_slot] && (tag_rd_q == page);
		sts.found      = hit_s2;
		sts.exhausted  = v_s2 && (pos_s2 == LAST_POS) && !hit_s2;
		sts.shift_done = (sh_q == stop_pos_q);
		sts.out_free   = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q   <= req_data.operation;
			addr_q <= ADDRESS_BITS'(req_data.address);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_last_q <= '0;
			data_last_q <= '0;
		end else if (cmd.finish) begin
			if (op_q) begin
				data_last_q <= slot_s2;
			end else begin
				code_last_q <= slot_s2;
			end
		end
	end

	always_comb begin
		if (cmd.load_req) begin
			tag_ra = req_data.operation ? data_last_q : code_last_q;
		end else begin
			tag_ra = slot_s1;
		end
		tag_re = cmd.load_req || cmd.scan_run;
		tag_we = cmd.finish && !hit_s2;
	end

	always_ff @(posedge clk) begin
		if (tag_re) begin
			tag_rd_q <= tag_mem[tag_ra];
		end
		if (tag_we) begin
			tag_mem[slot_s2] <= page;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_valid_q <= '0;
		end else if (tag_we) begin
			tag_valid_q[slot_s2] <= 1'b1;
		end
	end

	always_comb begin
		if (cmd.shift_run) begin
			order_ra = sh_q;
		end else if (cmd.scan_start) begin
			order_ra = '0;
		end else begin
			order_ra = pos_q;
		end
		order_re = cmd.scan_start || (cmd.scan_run && iss_q) || cmd.shift_run;
		order_wd = (sh_q == '0) ? res_slot_q : slot_s1;
	end

	// The shift reads an entry and writes the previous one into it in the same
	// cycle; the read returns the old contents.
	always_ff @(posedge clk) begin
		if (order_re) begin
			order_rd_q   <= order_mem[order_ra];
			order_set_s1 <= order_set_q[order_ra];
			pos_s1       <= order_ra;
		end
		if (cmd.shift_run) begin
			order_mem[sh_q] <= order_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_set_q <= '0;
		end else if (cmd.shift_run) begin
			order_set_q[sh_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			iss_q <= 1'b0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else if (cmd.scan_start) begin
			pos_q <= SLOT_W'(1);
			iss_q <= 1'b1;
			v_s1  <= 1'b1;
			v_s2  <= 1'b0;
		end else if (cmd.scan_run) begin
			v_s1 <= iss_q;
			v_s2 <= v_s1;
			if (iss_q) begin
				pos_q <= pos_q + SLOT_W'(1);
				iss_q <= (pos_q != LAST_POS);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_run) begin
			pos_s2  <= pos_s1;
			slot_s2 <= slot_s1;
		end
		if (cmd.finish) begin
			res_slot_q <= slot_s2;
			stop_pos_q <= pos_s2;
			fill_q     <= !hit_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_q <= '0;
		end else if (cmd.finish) begin
			sh_q <= '0;
		end else if (cmd.shift_run) begin
			sh_q <= sh_q + SLOT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_from_check) begin
				out_data.in_resident <= resident;
				out_data.slot        <= resident ? '0 : O_SLOT'(last_slot);
				out_data.offset      <= resident ? '0 : O_OFF'(offs);
				out_data.buffer_hit  <= !resident;
				out_data.fill_needed <= 1'b0;
				out_data.fill_page   <= '0;
			end else begin
				out_data.in_resident <= 1'b0;
				out_data.slot        <= O_SLOT'(res_slot_q);
				out_data.offset      <= O_OFF'(offs);
				out_data.buffer_hit  <= 1'b0;
				out_data.fill_needed <= fill_q;
				out_data.fill_page   <= fill_q ? O_PAGE'(page) : '0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/paged_lru_cache_directory.sv
// Top level of the paged LRU cache directory: APB register, controller and
// datapath. Depends on plcd_pkg, plcd_stream_if, plcd_ctrl and plcd_dp.
//
// Usage: requests (operation, address) arrive on the req stream, one result
// per request leaves on the rsp stream in request order. The resident_limit
// register sits at byte address 0 of the APB port; the user must write it only
// while no request is in flight, and the block does not enforce this.
// A request is taken and then checked in the next cycle. A resident data read
// or a hit in the stream's last-slot buffer places its result in the output
// register at the end of the check once that register is free; a new request
// is taken only once the controller is back in idle. A buffer miss walks the
// recency memory one position per cycle through a two-stage read pipeline,
// then moves the slot to the front one entry per cycle; a fill replaces the
// slot at recency position SLOTS-1.
// After reset all slots are invalid and the recency order is slot index
// order; valid bits cover both memories, so no clearing pass is needed.
// When the receiver stalls, the result waits in the output register and the
// next request is still taken and checked; it completes once that register
// frees.
module paged_lru_cache_directory #(
	parameter int SLOTS        = 64,
	parameter int PAGE_BYTES   = 512,
	parameter int ADDRESS_BITS = 19
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	plcd_stream_if.sink                          req,
	plcd_stream_if.source                        rsp,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [plcd_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  logic [plcd_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [plcd_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                 pready
);

	localparam int LIM_W = plcd_pkg::LIMIT_BITS;
	localparam int DAT_W = plcd_pkg::APB_DATA_BITS;

	logic [LIM_W-1:0] resident_limit_q;
	logic             reg_idx;
	logic             wr_en;
	plcd_pkg::cmd_t   cmd;
	plcd_pkg::sts_t   sts;

	assign pready  = 1'b1;
	assign reg_idx = paddr[plcd_pkg::APB_ADDR_BITS-1];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resident_limit_q <= '0;
		end else if (wr_en && (reg_idx == plcd_pkg::REG_RESIDENT_LIMIT)) begin
			resident_limit_q <= pwdata[LIM_W-1:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			plcd_pkg::REG_RESIDENT_LIMIT: prdata = DAT_W'(resident_limit_q);
			default:                      prdata = '0;
		endcase
	end

	plcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	plcd_dp #(
		.SLOTS        (SLOTS),
		.PAGE_BYTES   (PAGE_BYTES),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.req_data       (req.payload),
		.resident_limit (resident_limit_q),
		.out_valid      (rsp.valid),
		.out_ready      (rsp.ready),
		.out_data       (rsp.payload)
	);

endmodule

// File: rtl/plcd_checker.sv
// Port-level checks for the cache directory, bound to the top level.
// Depends on plcd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module plcd_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input plcd_pkg::rsp_t out_data
);

	`ASSERT_IMPL(a_resident_clean, clk, arst_n, out_valid && out_data.in_resident, out_data.slot == '0 && out_data.offset == '0 && !out_data.buffer_hit && !out_data.fill_needed && out_data.fill_page == '0)
	`ASSERT_IMPL(a_hit_no_fill, clk, arst_n, out_valid && out_data.buffer_hit, !out_data.fill_needed)
	`ASSERT_IMPL(a_page_only_on_fill, clk, arst_n, out_valid && !out_data.fill_needed, out_data.fill_page == '0)
	`ASSERT_NEXT(a_one_request_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready)
	`ASSERT_NEXT(a_result_held, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind paged_lru_cache_directory plcd_checker u_plcd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.out_data  (rsp.payload)
);
